// ===== sv/risc_subset_instruction_executor_defines.svh =====
// assertion macros for the instruction executor
`ifndef RISC_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define RISC_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RSIE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsie same-cycle check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define RSIE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsie next-cycle check failed");

`endif

// ===== sv/rsie_pkg.sv =====
// shared constants, codes and types of the instruction executor
`timescale 1ns / 1ps

package rsie_pkg;

	localparam int XLEN      = 32;
	localparam int REG_DEPTH = 32;
	localparam int REG_AW    = $clog2(REG_DEPTH);
	localparam int MEM_WORDS = 256;
	localparam int MEM_AW    = $clog2(MEM_WORDS);

	// opcodes
	localparam logic [5:0] OPC_RTYPE = 6'd0;
	localparam logic [5:0] OPC_BEQ   = 6'd4;
	localparam logic [5:0] OPC_BNE   = 6'd5;
	localparam logic [5:0] OPC_ADDI  = 6'd8;
	localparam logic [5:0] OPC_LW    = 6'd35;
	localparam logic [5:0] OPC_SW    = 6'd43;

	// R-format function codes
	localparam logic [5:0] FN_ADD = 6'd32;
	localparam logic [5:0] FN_SUB = 6'd34;
	localparam logic [5:0] FN_AND = 6'd36;
	localparam logic [5:0] FN_OR  = 6'd37;
	localparam logic [5:0] FN_XOR = 6'd38;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_FUNCT  = 2'd1,
		ST_BAD_OPCODE = 2'd2,
		ST_BAD_ADDR   = 2'd3
	} status_t;

	// register file write request
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] idx;
		logic [XLEN-1:0]   data;
	} reg_wr_t;

	// data memory write request
	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [XLEN-1:0]   data;
	} mem_wr_t;

endpackage

// ===== sv/rsie_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps

module rsie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/rsie_regfile.sv =====
// register file: two read copies, reset-value tracking and last-write bypass
`timescale 1ns / 1ps

module rsie_regfile (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [rsie_pkg::REG_AW-1:0]  rs_idx,
	input  logic [rsie_pkg::REG_AW-1:0]  rt_idx,
	input  rsie_pkg::reg_wr_t            wr,
	output logic [rsie_pkg::XLEN-1:0]    rs_data,
	output logic [rsie_pkg::XLEN-1:0]    rt_data
);

	logic [rsie_pkg::REG_DEPTH-1:0] vld_q;
	logic                           rs_vld_q;
	logic                           rt_vld_q;
	logic [rsie_pkg::REG_AW-1:0]    rs_idx_q;
	logic [rsie_pkg::REG_AW-1:0]    rt_idx_q;
	rsie_pkg::reg_wr_t              last_q;
	logic [rsie_pkg::XLEN-1:0]      rs_ram;
	logic [rsie_pkg::XLEN-1:0]      rt_ram;

	rsie_ram #(.WIDTH(rsie_pkg::XLEN), .DEPTH(rsie_pkg::REG_DEPTH)) u_ram_rs (
		.clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
		.re(rd_en), .raddr(rs_idx), .rdata(rs_ram)
	);

	rsie_ram #(.WIDTH(rsie_pkg::XLEN), .DEPTH(rsie_pkg::REG_DEPTH)) u_ram_rt (
		.clk(clk), .we(wr.en), .waddr(wr.idx), .wdata(wr.data),
		.re(rd_en), .raddr(rt_idx), .rdata(rt_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rs_vld_q <= 1'b0;
			rt_vld_q <= 1'b0;
			last_q   <= '0;
		end else begin
			if (rd_en) begin
				rs_vld_q <= vld_q[rs_idx];
				rt_vld_q <= vld_q[rt_idx];
			end
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
				last_q        <= wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rs_idx_q <= rs_idx;
			rt_idx_q <= rt_idx;
		end
	end

	// last write covers a read that met it on the same edge
	always_comb begin
		if (last_q.en && last_q.idx == rs_idx_q) begin
			rs_data = last_q.data;
		end else if (rs_vld_q) begin
			rs_data = rs_ram;
		end else begin
			rs_data = rsie_pkg::XLEN'(rs_idx_q);
		end
		if (last_q.en && last_q.idx == rt_idx_q) begin
			rt_data = last_q.data;
		end else if (rt_vld_q) begin
			rt_data = rt_ram;
		end else begin
			rt_data = rsie_pkg::XLEN'(rt_idx_q);
		end
	end

endmodule

// ===== sv/rsie_dmem.sv =====
// data memory: reset-value tracking per word and last-write bypass
`timescale 1ns / 1ps

module rsie_dmem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [rsie_pkg::MEM_AW-1:0] rd_addr,
	input  rsie_pkg::mem_wr_t           wr,
	output logic [rsie_pkg::XLEN-1:0]   rd_data
);

	logic [rsie_pkg::MEM_WORDS-1:0] vld_q;
	logic                           rd_vld_q;
	logic [rsie_pkg::MEM_AW-1:0]    rd_addr_q;
	rsie_pkg::mem_wr_t              last_q;
	logic [rsie_pkg::XLEN-1:0]      ram_data;

	rsie_ram #(.WIDTH(rsie_pkg::XLEN), .DEPTH(rsie_pkg::MEM_WORDS)) u_ram (
		.clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
		.re(rd_en), .raddr(rd_addr), .rdata(ram_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			last_q   <= '0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
				last_q         <= wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_q <= rd_addr;
		end
	end

	always_comb begin
		if (last_q.en && last_q.addr == rd_addr_q) begin
			rd_data = last_q.data;
		end else if (rd_vld_q) begin
			rd_data = ram_data;
		end else begin
			rd_data = rsie_pkg::XLEN'(rd_addr_q);
		end
	end

endmodule

// ===== sv/risc_subset_instruction_executor.sv =====
// Executes one instruction word per request (add, sub, and, or, xor, addi, lw, sw,
// beq, bne) against a 32-entry register file and a 256-word data memory, both held
// in synchronous rams with a registered read. Sustained rate is one request per cycle
// while the output is not stalled; each result is shown from the stage 2 register
// (two-stage pipe: register read and execute, then memory read and result). The rate
// is set by the register file read in the first stage and the data memory read in
// the second; writes to both stores happen when the result is taken, and values still
// on their way to a store are bypassed to younger requests. Both stores come out of
// reset with their index as contents through per-entry valid flops, so there is no
// clearing pass and the block takes requests straight after reset. A stalled output
// holds its result while the input side still fills an empty first stage.
`timescale 1ns / 1ps
`include "risc_subset_instruction_executor_defines.svh"

module risc_subset_instruction_executor (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instruction,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               is_r_format,
	output logic               branch_taken,
	output logic               reg_write_valid,
	output logic [4:0]         reg_write_index,
	output logic signed [31:0] reg_write_value,
	output logic               mem_write_valid,
	output logic signed [31:0] mem_address
);

	// pipe control
	logic en1;
	logic en2;
	logic in_acc;
	logic out_acc;

	// stage 1: request waiting on register read data
	logic        valid_s1;
	logic [31:0] instr_s1;

	// stage 2: executed result, also the output register
	logic                          valid_s2;
	rsie_pkg::status_t             status_s2;
	logic                          is_r_s2;
	logic                          br_s2;
	logic                          rwv_s2;
	logic [rsie_pkg::REG_AW-1:0]   rwidx_s2;
	logic [rsie_pkg::XLEN-1:0]     alu_s2;
	logic                          lw_s2;
	logic                          mwv_s2;
	logic [rsie_pkg::XLEN-1:0]     addr_s2;
	logic [rsie_pkg::XLEN-1:0]     sdata_s2;

	// store interfaces
	logic [rsie_pkg::XLEN-1:0] rf_rs;
	logic [rsie_pkg::XLEN-1:0] rf_rt;
	logic [rsie_pkg::XLEN-1:0] mem_rdata;
	rsie_pkg::reg_wr_t         rf_wr;
	rsie_pkg::mem_wr_t         mem_wr;
	logic [rsie_pkg::XLEN-1:0] wb_value;

	// stage 1 decode and execute
	logic [5:0]                  opc;
	logic [5:0]                  fn;
	logic [rsie_pkg::REG_AW-1:0] rs;
	logic [rsie_pkg::REG_AW-1:0] rt;
	logic [rsie_pkg::REG_AW-1:0] rd;
	logic [rsie_pkg::XLEN-1:0]   imm_x;
	logic [rsie_pkg::XLEN-1:0]   op_a;
	logic [rsie_pkg::XLEN-1:0]   op_b;
	logic [rsie_pkg::XLEN-1:0]   eff_addr;
	logic                        in_range;
	rsie_pkg::status_t           ex_status;
	logic                        ex_br;
	logic                        ex_wreq;
	logic [rsie_pkg::REG_AW-1:0] ex_widx;
	logic [rsie_pkg::XLEN-1:0]   ex_val;
	logic                        ex_load;
	logic                        ex_store;
	logic                        ex_is_mem;
	logic                        ex_rwv;

	// the output register frees when empty or taken; stage 1 frees when it can move on
	assign en2      = !valid_s2 || !out_stall;
	assign en1      = !valid_s1 || en2;
	assign in_stall = !en1;
	assign in_acc   = in_valid && en1;
	assign out_acc  = valid_s2 && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= in_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1 <= instruction;
		end
	end

	// register read is issued as the request is taken
	rsie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rs_idx  (instruction[25:21]),
		.rt_idx  (instruction[20:16]),
		.wr      (rf_wr),
		.rs_data (rf_rs),
		.rt_data (rf_rt)
	);

	// load data lands as the request enters stage 2
	rsie_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en2 && valid_s1),
		.rd_addr (eff_addr[rsie_pkg::MEM_AW-1:0]),
		.wr      (mem_wr),
		.rd_data (mem_rdata)
	);

	// value written back by the result in stage 2
	assign wb_value = lw_s2 ? mem_rdata : alu_s2;

	// stores are updated when the result is taken
	always_comb begin
		rf_wr.en    = out_acc && rwv_s2;
		rf_wr.idx   = rwidx_s2;
		rf_wr.data  = wb_value;
		mem_wr.en   = out_acc && mwv_s2;
		mem_wr.addr = addr_s2[rsie_pkg::MEM_AW-1:0];
		mem_wr.data = sdata_s2;
	end

	// field split
	assign opc   = instr_s1[31:26];
	assign rs    = instr_s1[25:21];
	assign rt    = instr_s1[20:16];
	assign rd    = instr_s1[15:11];
	assign fn    = instr_s1[5:0];
	assign imm_x = {{16{instr_s1[15]}}, instr_s1[15:0]};

	// bypass of the older result still sitting in stage 2
	always_comb begin
		if (valid_s2 && rwv_s2 && rwidx_s2 == rs) begin
			op_a = wb_value;
		end else begin
			op_a = rf_rs;
		end
		if (valid_s2 && rwv_s2 && rwidx_s2 == rt) begin
			op_b = wb_value;
		end else begin
			op_b = rf_rt;
		end
	end

	// negative addresses wrap to large unsigned values and fail the range check
	assign eff_addr = op_a + imm_x;
	assign in_range = eff_addr < rsie_pkg::XLEN'(rsie_pkg::MEM_WORDS);

	always_comb begin
		ex_status = rsie_pkg::ST_OK;
		ex_br     = 1'b0;
		ex_wreq   = 1'b0;
		ex_widx   = rt;
		ex_val    = '0;
		ex_load   = 1'b0;
		ex_store  = 1'b0;
		ex_is_mem = 1'b0;
		case (opc)
			rsie_pkg::OPC_RTYPE: begin
				ex_widx = rd;
				case (fn)
					rsie_pkg::FN_ADD: begin
						ex_wreq = 1'b1;
						ex_val  = op_a + op_b;
					end
					rsie_pkg::FN_SUB: begin
						ex_wreq = 1'b1;
						ex_val  = op_a - op_b;
					end
					rsie_pkg::FN_AND: begin
						ex_wreq = 1'b1;
						ex_val  = op_a & op_b;
					end
					rsie_pkg::FN_OR: begin
						ex_wreq = 1'b1;
						ex_val  = op_a | op_b;
					end
					rsie_pkg::FN_XOR: begin
						ex_wreq = 1'b1;
						ex_val  = op_a ^ op_b;
					end
					default: begin
						ex_status = rsie_pkg::ST_BAD_FUNCT;
					end
				endcase
			end
			rsie_pkg::OPC_ADDI: begin
				ex_wreq = 1'b1;
				ex_val  = op_a + imm_x;
			end
			rsie_pkg::OPC_LW, rsie_pkg::OPC_SW: begin
				ex_is_mem = 1'b1;
				if (!in_range) begin
					ex_status = rsie_pkg::ST_BAD_ADDR;
				end else if (opc == rsie_pkg::OPC_LW) begin
					ex_wreq = 1'b1;
					ex_load = 1'b1;
				end else begin
					ex_store = 1'b1;
				end
			end
			rsie_pkg::OPC_BEQ: begin
				ex_br = op_a == op_b;
			end
			rsie_pkg::OPC_BNE: begin
				ex_br = op_a != op_b;
			end
			default: begin
				ex_status = rsie_pkg::ST_BAD_OPCODE;
			end
		endcase
	end

	// writes to register zero are dropped and leave the write fields clear
	assign ex_rwv = ex_wreq && (ex_widx != '0);

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			status_s2 <= ex_status;
			is_r_s2   <= opc == rsie_pkg::OPC_RTYPE;
			br_s2     <= ex_br;
			rwv_s2    <= ex_rwv;
			rwidx_s2  <= ex_rwv ? ex_widx : '0;
			alu_s2    <= (ex_rwv && !ex_load) ? ex_val : '0;
			lw_s2     <= ex_rwv && ex_load;
			mwv_s2    <= ex_store;
			addr_s2   <= ex_is_mem ? eff_addr : '0;
			sdata_s2  <= op_b;
		end
	end

	// result port
	assign out_valid       = valid_s2;
	assign status          = status_s2;
	assign is_r_format     = is_r_s2;
	assign branch_taken    = br_s2;
	assign reg_write_valid = rwv_s2;
	assign reg_write_index = rwidx_s2;
	assign reg_write_value = wb_value;
	assign mem_write_valid = mwv_s2;
	assign mem_address     = addr_s2;

	// a write result never names register zero
	`RSIE_ASSERT_NOW(a_no_r0_write, valid_s2 && rwv_s2, rwidx_s2 != '0)
	// one instruction never writes both stores
	`RSIE_ASSERT_NOW(a_one_store, valid_s2, !(rwv_s2 && mwv_s2))
	// a failed instruction changes nothing
	`RSIE_ASSERT_NOW(a_err_no_write, valid_s2 && status_s2 != rsie_pkg::ST_OK, !rwv_s2 && !mwv_s2)
	// the input only stalls with both stages full
	`RSIE_ASSERT_NOW(a_stall_full, in_stall, valid_s1 && valid_s2)
	// a held result stays held for the next cycle
	`RSIE_ASSERT_NEXT(a_hold, valid_s2 && out_stall, valid_s2 && $stable(rwidx_s2))

endmodule

// ===== dv/risc_subset_instruction_executor_tb.sv =====
// self-checking testbench of the instruction executor with a shadow datapath for prediction
`timescale 1ns / 1ps

module risc_subset_instruction_executor_tb;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 4;
	localparam int RANDOM_COUNT = 1400;
	// sender waits for an empty pipe once this many requests have gone out
	localparam int DRAIN_AT     = 700;
	// receiver holds off for a long stretch once this many results have come
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 64;
	// idle tail after the last result, ample for a two-stage pipe
	localparam int TAIL_CYCLES  = 8;
	localparam int IDLE_LIMIT   = 4000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// one retired instruction as seen on the result channel
	typedef struct {
		rsie_pkg::status_t status;
		logic              is_r;
		logic              taken;
		logic              rw_valid;
		logic [4:0]        rw_index;
		logic [31:0]       rw_value;
		logic              mw_valid;
		logic [31:0]       mem_addr;
	} exec_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [31:0]        instruction = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic               is_r_format;
	logic               branch_taken;
	logic               reg_write_valid;
	logic [4:0]         reg_write_index;
	logic signed [31:0] reg_write_value;
	logic               mem_write_valid;
	logic signed [31:0] mem_address;

	// shadow copies of the architectural state
	logic [31:0] reg_shadow [rsie_pkg::REG_DEPTH];
	logic [31:0] mem_shadow [rsie_pkg::MEM_WORDS];

	logic [31:0]  program_words [$];
	exec_result_t retire_queue [$];

	int error_count = 0;
	int sent_count = 0;
	int retired_count = 0;
	int idle_cycles = 0;

	// sender state
	int          burst_left = 0;
	int          gap_left = 0;
	bit          drain_wait = 1'b0;
	bit          drain_done = 1'b0;
	logic        offer_now;
	logic [31:0] offer_word;

	// receiver state
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          stall_tick = 0;
	logic        stall_next;
	exec_result_t due;

	risc_subset_instruction_executor uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.instruction     (instruction),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.is_r_format     (is_r_format),
		.branch_taken    (branch_taken),
		.reg_write_valid (reg_write_valid),
		.reg_write_index (reg_write_index),
		.reg_write_value (reg_write_value),
		.mem_write_valid (mem_write_valid),
		.mem_address     (mem_address)
	);

	always #CLK_HALF clk = ~clk;

	// instruction word builders
	function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [4:0] shamt, input logic [5:0] fn);
		return {rsie_pkg::OPC_RTYPE, rs, rt, rd, shamt, fn};
	endfunction

	function automatic logic [31:0] i_word(input logic [5:0] opc, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	// register index biased towards a few low registers so that hazards are frequent
	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 1) == 0)
			return 5'($urandom_range(0, 7));
		return 5'($urandom_range(0, 31));
	endfunction

	// mostly well-formed instructions with random content, the rest noise
	function automatic logic [31:0] random_word();
		int          pick;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [15:0] imm;
		logic [5:0]  opc;
		pick = $urandom_range(0, 99);
		rs = pick_reg();
		rt = pick_reg();
		if (pick < 8)
			return $urandom;
		if (pick < 12)
			return r_word(rs, rt, pick_reg(), 5'($urandom), 6'($urandom));
		if (pick < 15)
			return i_word(6'($urandom_range(1, 63)), rs, rt, 16'($urandom));
		case ($urandom_range(0, 9))
			0: return r_word(rs, rt, pick_reg(), 5'($urandom), rsie_pkg::FN_ADD);
			1: return r_word(rs, rt, pick_reg(), 5'($urandom), rsie_pkg::FN_SUB);
			2: return r_word(rs, rt, pick_reg(), 5'($urandom), rsie_pkg::FN_AND);
			3: return r_word(rs, rt, pick_reg(), 5'($urandom), rsie_pkg::FN_OR);
			4: return r_word(rs, rt, pick_reg(), 5'($urandom), rsie_pkg::FN_XOR);
			5: begin
				imm = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
				return i_word(rsie_pkg::OPC_ADDI, rs, rt, imm);
			end
			6, 7: begin
				opc = ($urandom_range(0, 1) == 0) ? rsie_pkg::OPC_LW : rsie_pkg::OPC_SW;
				pick = $urandom_range(0, 99);
				// register zero as base keeps most addresses inside memory
				if (pick < 70)
					return i_word(opc, 5'd0, rt, 16'($urandom_range(0, rsie_pkg::MEM_WORDS - 1)));
				if (pick < 85)
					return i_word(opc, rs, rt, 16'($urandom_range(0, 31)));
				return i_word(opc, 5'd0, rt, 16'($urandom));
			end
			8: begin
				if ($urandom_range(0, 4) < 2)
					rt = rs;
				return i_word(rsie_pkg::OPC_BEQ, rs, rt, 16'($urandom));
			end
			default: begin
				if ($urandom_range(0, 4) < 2)
					rt = rs;
				return i_word(rsie_pkg::OPC_BNE, rs, rt, 16'($urandom));
			end
		endcase
	endfunction

	// register write, dropped for register zero
	function automatic void commit_reg(inout exec_result_t r, input logic [4:0] idx,
			input logic [31:0] val);
		if (idx != 5'd0) begin
			reg_shadow[idx] = val;
			r.rw_valid = 1'b1;
			r.rw_index = idx;
			r.rw_value = val;
		end
	endfunction

	// executes one instruction on the shadow state and returns what should retire
	function automatic exec_result_t execute_instruction(input logic [31:0] word);
		exec_result_t r;
		logic [5:0]   opc;
		logic [5:0]   fn;
		logic [4:0]   rs;
		logic [4:0]   rt;
		logic [4:0]   rd;
		logic [31:0]  a;
		logic [31:0]  b;
		logic [31:0]  imm;
		logic [31:0]  addr;
		opc = word[31:26];
		rs = word[25:21];
		rt = word[20:16];
		rd = word[15:11];
		fn = word[5:0];
		imm = {{16{word[15]}}, word[15:0]};
		a = reg_shadow[rs];
		b = reg_shadow[rt];
		r.status = rsie_pkg::ST_OK;
		r.is_r = 1'b0;
		r.taken = 1'b0;
		r.rw_valid = 1'b0;
		r.rw_index = '0;
		r.rw_value = '0;
		r.mw_valid = 1'b0;
		r.mem_addr = '0;
		if (opc == rsie_pkg::OPC_RTYPE) begin
			r.is_r = 1'b1;
			case (fn)
				rsie_pkg::FN_ADD: commit_reg(r, rd, a + b);
				rsie_pkg::FN_SUB: commit_reg(r, rd, a - b);
				rsie_pkg::FN_AND: commit_reg(r, rd, a & b);
				rsie_pkg::FN_OR: commit_reg(r, rd, a | b);
				rsie_pkg::FN_XOR: commit_reg(r, rd, a ^ b);
				default: r.status = rsie_pkg::ST_BAD_FUNCT;
			endcase
		end else begin
			case (opc)
				rsie_pkg::OPC_ADDI: commit_reg(r, rt, a + imm);
				rsie_pkg::OPC_LW, rsie_pkg::OPC_SW: begin
					addr = a + imm;
					r.mem_addr = addr;
					// negative addresses are huge when unsigned, so one compare covers both
					if (addr >= 32'(rsie_pkg::MEM_WORDS))
						r.status = rsie_pkg::ST_BAD_ADDR;
					else if (opc == rsie_pkg::OPC_LW)
						commit_reg(r, rt, mem_shadow[addr[rsie_pkg::MEM_AW-1:0]]);
					else begin
						mem_shadow[addr[rsie_pkg::MEM_AW-1:0]] = b;
						r.mw_valid = 1'b1;
					end
				end
				rsie_pkg::OPC_BEQ: r.taken = (a == b);
				rsie_pkg::OPC_BNE: r.taken = (a != b);
				default: r.status = rsie_pkg::ST_BAD_OPCODE;
			endcase
		end
		return r;
	endfunction

	// driver: predicts on every accepted request, then offers the next one in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			instruction <= '0;
		end else begin
			if (in_valid && !in_stall)
				retire_queue.push_back(execute_instruction(instruction));
			// a stalled request holds its word and valid
			if (!(in_valid && in_stall)) begin
				offer_now = 1'b0;
				offer_word = instruction;
				if (drain_wait) begin
					if (retire_queue.size() == 0) begin
						drain_wait = 1'b0;
						drain_done = 1'b1;
					end
				end else if (gap_left > 0) begin
					gap_left--;
				end else if (program_words.size() > 0) begin
					if (!drain_done && sent_count == DRAIN_AT) begin
						// pause until the pipe has emptied out
						drain_wait = 1'b1;
					end else begin
						offer_now = 1'b1;
						offer_word = program_words.pop_front();
						sent_count++;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 24);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end
					end
				end
				in_valid <= offer_now;
				instruction <= offer_word;
			end
		end
	end

	// monitor: checks each retired result and drives the stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				retired_count++;
				if (retire_queue.size() == 0) begin
					$error("result retired with no request outstanding");
					error_count++;
				end else begin
					due = retire_queue.pop_front();
					if (status !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, status);
						error_count++;
					end
					if (is_r_format !== due.is_r) begin
						$error("is_r_format: expected %0d, got %0d", due.is_r, is_r_format);
						error_count++;
					end
					if (branch_taken !== due.taken) begin
						$error("branch_taken: expected %0d, got %0d", due.taken, branch_taken);
						error_count++;
					end
					if (reg_write_valid !== due.rw_valid) begin
						$error("reg_write_valid: expected %0d, got %0d", due.rw_valid,
							reg_write_valid);
						error_count++;
					end
					if (reg_write_index !== due.rw_index) begin
						$error("reg_write_index: expected %0d, got %0d", due.rw_index,
							reg_write_index);
						error_count++;
					end
					if (reg_write_value !== due.rw_value) begin
						$error("reg_write_value: expected %h, got %h", due.rw_value,
							reg_write_value);
						error_count++;
					end
					if (mem_write_valid !== due.mw_valid) begin
						$error("mem_write_valid: expected %0d, got %0d", due.mw_valid,
							mem_write_valid);
						error_count++;
					end
					if (mem_address !== due.mem_addr) begin
						$error("mem_address: expected %h, got %h", due.mem_addr, mem_address);
						error_count++;
					end
				end
			end
			// long hold-off once, so the pipe fills and back-pressures the sender
			stall_tick++;
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && retired_count >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				stall_next = 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 60);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE: stall_next = 1'b0;
					STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
					default: stall_next = (stall_tick % 3 == 0);
				endcase
			end
			out_stall <= stall_next;
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < rsie_pkg::REG_DEPTH; i++)
			reg_shadow[i] = 32'(i);
		for (int i = 0; i < rsie_pkg::MEM_WORDS; i++)
			mem_shadow[i] = 32'(i);

		// directed part: registers start at their index, so values are known
		program_words.push_back(r_word(5'd2, 5'd3, 5'd1, 5'd0, rsie_pkg::FN_ADD));
		// gives all ones
		program_words.push_back(r_word(5'd5, 5'd6, 5'd4, 5'd0, rsie_pkg::FN_SUB));
		program_words.push_back(r_word(5'd4, 5'd3, 5'd7, 5'd0, rsie_pkg::FN_AND));
		program_words.push_back(r_word(5'd8, 5'd10, 5'd9, 5'd0, rsie_pkg::FN_OR));
		program_words.push_back(r_word(5'd4, 5'd12, 5'd11, 5'd0, rsie_pkg::FN_XOR));
		// wraps past 32 bits
		program_words.push_back(r_word(5'd4, 5'd2, 5'd14, 5'd0, rsie_pkg::FN_ADD));
		// write to register zero
		program_words.push_back(r_word(5'd2, 5'd3, 5'd0, 5'd0, rsie_pkg::FN_ADD));
		program_words.push_back(i_word(rsie_pkg::OPC_ADDI, 5'd0, 5'd15, 16'h7FFF));
		// negative immediate
		program_words.push_back(i_word(rsie_pkg::OPC_ADDI, 5'd0, 5'd16, 16'h8000));
		// shamt ignored
		program_words.push_back(r_word(5'd15, 5'd16, 5'd17, 5'd31, rsie_pkg::FN_ADD));
		// last memory word
		program_words.push_back(i_word(rsie_pkg::OPC_LW, 5'd0, 5'd18, 16'd255));
		// just past the end
		program_words.push_back(i_word(rsie_pkg::OPC_LW, 5'd0, 5'd19, 16'd256));
		// negative address
		program_words.push_back(i_word(rsie_pkg::OPC_LW, 5'd0, 5'd20, 16'hFFFF));
		program_words.push_back(i_word(rsie_pkg::OPC_SW, 5'd0, 5'd4, 16'd0));
		// load right after store
		program_words.push_back(i_word(rsie_pkg::OPC_LW, 5'd0, 5'd21, 16'd0));
		// store out of range
		program_words.push_back(i_word(rsie_pkg::OPC_SW, 5'd0, 5'd1, 16'h8000));
		program_words.push_back(i_word(rsie_pkg::OPC_BEQ, 5'd3, 5'd3, 16'h1234));
		program_words.push_back(i_word(rsie_pkg::OPC_BEQ, 5'd1, 5'd2, 16'h0001));
		program_words.push_back(i_word(rsie_pkg::OPC_BNE, 5'd1, 5'd2, 16'hFFFF));
		program_words.push_back(i_word(rsie_pkg::OPC_BNE, 5'd5, 5'd5, 16'h0000));
		program_words.push_back(32'h0000_0000);                               // unknown funct
		program_words.push_back(r_word(5'd31, 5'd30, 5'd29, 5'd0, 6'h3F));
		program_words.push_back(32'hFFFF_FFFF);                               // unknown opcode
		program_words.push_back(i_word(6'd2, 5'd1, 5'd2, 16'h0040));
		// load into register zero
		program_words.push_back(i_word(rsie_pkg::OPC_LW, 5'd0, 5'd0, 16'd3));

		for (int i = 0; i < RANDOM_COUNT; i++)
			program_words.push_back(random_word());

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every request sent and every result retired
		while (program_words.size() != 0 || in_valid || retire_queue.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && retire_queue.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
